>>> rtl/mrac_pkg.sv
// Shared types, constants and the operation schedule for the MRAC step core.
`timescale 1ns / 1ps

package mrac_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int STEP_BITS = 31;
  localparam int CFG_IDX_BITS = 4;

  localparam int NUM_OPS = 29;
  localparam int OP_CNT_BITS = $clog2(NUM_OPS);
  localparam logic [OP_CNT_BITS-1:0] LAST_OP = OP_CNT_BITS'(NUM_OPS - 1);

  // Saturation bounds of the word, held at product width.
  localparam logic signed [PROD_BITS-1:0] SAT_HI =
    PROD_BITS'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE        = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL_A10        = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL_A11        = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MODEL_B1         = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ERROR_WEIGHT0    = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ERROR_WEIGHT1    = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_FEEDBACK    = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_FEEDFORWARD = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [STEP_BITS-1:0]        RST_STEP_SIZE        = 31'd655;
  localparam logic signed [WORD_BITS-1:0] RST_MODEL_A10        = -32'sd655360;
  localparam logic signed [WORD_BITS-1:0] RST_MODEL_A11        = -32'sd327680;
  localparam logic signed [WORD_BITS-1:0] RST_MODEL_B1         = 32'sd131072;
  localparam logic signed [WORD_BITS-1:0] RST_ERROR_WEIGHT0    = 32'sd131072;
  localparam logic signed [WORD_BITS-1:0] RST_ERROR_WEIGHT1    = 32'sd131072;
  localparam logic signed [WORD_BITS-1:0] RST_RATE_FEEDBACK    = 32'sd65536;
  localparam logic signed [WORD_BITS-1:0] RST_RATE_FEEDFORWARD = 32'sd65536;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_t;

  typedef enum logic [4:0] {
    R_MS0, R_MS1, R_PE0, R_PE1, R_PP0, R_PP1, R_FB0, R_FB1,
    R_FF, R_PR, R_T1, R_T2, R_T3, R_YR, R_POS, R_VEL,
    R_H, R_A10, R_A11, R_B1, R_W0, R_W1, R_R1, R_R2
  } reg_sel_t;

  typedef struct packed {
    op_t      op;
    reg_sel_t src_a;
    reg_sel_t src_b;
    reg_sel_t dst;
  } uop_t;

  // Operation schedule for one control tick. The last entry leaves u in T1.
  function automatic uop_t uop_at(input logic [OP_CNT_BITS-1:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = '{OP_MUL, R_A10, R_MS0, R_T1};  // a10*x0
      5'd1:  u = '{OP_MUL, R_A11, R_MS1, R_T2};  // a11*x1
      5'd2:  u = '{OP_ADD, R_T1,  R_T2,  R_T1};
      5'd3:  u = '{OP_MUL, R_B1,  R_PR,  R_T2};  // b1*r
      5'd4:  u = '{OP_ADD, R_T1,  R_T2,  R_T1};
      5'd5:  u = '{OP_MUL, R_H,   R_T1,  R_T1};
      5'd6:  u = '{OP_MUL, R_H,   R_MS1, R_T2};  // h*x1
      5'd7:  u = '{OP_ADD, R_MS0, R_T2,  R_MS0};
      5'd8:  u = '{OP_ADD, R_MS1, R_T1,  R_MS1};
      5'd9:  u = '{OP_MUL, R_W0,  R_PE0, R_T1};  // weighted error
      5'd10: u = '{OP_MUL, R_W1,  R_PE1, R_T2};
      5'd11: u = '{OP_ADD, R_T1,  R_T2,  R_T1};  // s
      5'd12: u = '{OP_MUL, R_H,   R_R1,  R_T2};
      5'd13: u = '{OP_MUL, R_T2,  R_T1,  R_T2};  // g
      5'd14: u = '{OP_MUL, R_T2,  R_PP0, R_T3};
      5'd15: u = '{OP_ADD, R_FB0, R_T3,  R_FB0};
      5'd16: u = '{OP_MUL, R_T2,  R_PP1, R_T3};
      5'd17: u = '{OP_ADD, R_FB1, R_T3,  R_FB1};
      5'd18: u = '{OP_MUL, R_H,   R_R2,  R_T2};
      5'd19: u = '{OP_MUL, R_T2,  R_T1,  R_T2};
      5'd20: u = '{OP_MUL, R_T2,  R_PR,  R_T2};
      5'd21: u = '{OP_ADD, R_FF,  R_T2,  R_FF};
      5'd22: u = '{OP_SUB, R_MS0, R_POS, R_PE0}; // tracking error
      5'd23: u = '{OP_SUB, R_MS1, R_VEL, R_PE1};
      5'd24: u = '{OP_MUL, R_FF,  R_YR,  R_T1};  // drive terms
      5'd25: u = '{OP_MUL, R_FB0, R_POS, R_T2};
      5'd26: u = '{OP_ADD, R_T1,  R_T2,  R_T1};
      5'd27: u = '{OP_MUL, R_FB1, R_VEL, R_T2};
      5'd28: u = '{OP_ADD, R_T1,  R_T2,  R_T1};
      default: u = '{OP_ADD, R_T1, R_T1, R_T3};
    endcase
    return u;
  endfunction

endpackage

>>> rtl/mrac_second_order_step_core.sv
// Top level of the second-order MRAC step core: sequencer around one shared
// multiply/add unit with saturation.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | to core   | in_valid / in_ready   | ref_sample, plant_pos, plant_vel
//   out     | from core | out_valid / out_ready | drive, overflow
//   cfg     | to core   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request runs 29 operations through a shared 32x32 multiplier and
// saturating adder; each operation first forms the raw result, then (for
// products) shifts and rounds toward zero, and saturates. The core takes no
// new request until the result is out; it holds the result until it is
// taken and accepts the next request in the cycle after that.
// Reset (synchronous, rst high) restores register defaults and zeroes state.
// Configuration writes are always taken; cfg_ready stays high.
`timescale 1ns / 1ps

module mrac_second_order_step_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [mrac_pkg::WORD_BITS-1:0]  ref_sample,
  input  logic signed [mrac_pkg::WORD_BITS-1:0]  plant_pos,
  input  logic signed [mrac_pkg::WORD_BITS-1:0]  plant_vel,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [mrac_pkg::WORD_BITS-1:0]  drive,
  output logic                                   overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mrac_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mrac_pkg::WORD_BITS-1:0]         cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB,
    S_DONE
  } state_t;

  state_t state;
  logic [mrac_pkg::OP_CNT_BITS-1:0] op_idx;

  // Configuration registers.
  logic [mrac_pkg::STEP_BITS-1:0]        step_size;
  logic signed [mrac_pkg::WORD_BITS-1:0] model_a10, model_a11, model_b1;
  logic signed [mrac_pkg::WORD_BITS-1:0] error_weight0, error_weight1;
  logic signed [mrac_pkg::WORD_BITS-1:0] rate_feedback, rate_feedforward;

  // Controller state kept across ticks.
  logic signed [mrac_pkg::WORD_BITS-1:0] ms0, ms1, pe0, pe1, pp0, pp1;
  logic signed [mrac_pkg::WORD_BITS-1:0] fb0, fb1, ff, pr;

  // Working registers for one tick.
  logic signed [mrac_pkg::WORD_BITS-1:0] t1, t2, t3, yr, pos, vel;
  logic signed [mrac_pkg::PROD_BITS-1:0] raw;
  logic                                  ovf;

  mrac_pkg::uop_t uop;
  logic signed [mrac_pkg::WORD_BITS-1:0] a_val, b_val;
  logic signed [mrac_pkg::PROD_BITS-1:0] prod, sum, raw_next;
  logic signed [mrac_pkg::PROD_BITS-1:0] shifted, corr, q_wide;
  logic signed [mrac_pkg::WORD_BITS-1:0] q;
  logic                                  q_sat;

  function automatic logic signed [mrac_pkg::WORD_BITS-1:0] rd(
    input mrac_pkg::reg_sel_t sel,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_ms0, v_ms1, v_pe0, v_pe1,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_pp0, v_pp1, v_fb0, v_fb1,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_ff, v_pr, v_t1, v_t2, v_t3,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_yr, v_pos, v_vel, v_h,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_a10, v_a11, v_b1, v_w0,
    input logic signed [mrac_pkg::WORD_BITS-1:0] v_w1, v_r1, v_r2
  );
    logic signed [mrac_pkg::WORD_BITS-1:0] v;
    case (sel)
      mrac_pkg::R_MS0: v = v_ms0;
      mrac_pkg::R_MS1: v = v_ms1;
      mrac_pkg::R_PE0: v = v_pe0;
      mrac_pkg::R_PE1: v = v_pe1;
      mrac_pkg::R_PP0: v = v_pp0;
      mrac_pkg::R_PP1: v = v_pp1;
      mrac_pkg::R_FB0: v = v_fb0;
      mrac_pkg::R_FB1: v = v_fb1;
      mrac_pkg::R_FF:  v = v_ff;
      mrac_pkg::R_PR:  v = v_pr;
      mrac_pkg::R_T1:  v = v_t1;
      mrac_pkg::R_T2:  v = v_t2;
      mrac_pkg::R_T3:  v = v_t3;
      mrac_pkg::R_YR:  v = v_yr;
      mrac_pkg::R_POS: v = v_pos;
      mrac_pkg::R_VEL: v = v_vel;
      mrac_pkg::R_H:   v = v_h;
      mrac_pkg::R_A10: v = v_a10;
      mrac_pkg::R_A11: v = v_a11;
      mrac_pkg::R_B1:  v = v_b1;
      mrac_pkg::R_W0:  v = v_w0;
      mrac_pkg::R_W1:  v = v_w1;
      mrac_pkg::R_R1:  v = v_r1;
      mrac_pkg::R_R2:  v = v_r2;
      default:         v = '0;
    endcase
    return v;
  endfunction

  logic signed [mrac_pkg::WORD_BITS-1:0] h_word;
  assign h_word = $signed({1'b0, step_size});

  assign uop = mrac_pkg::uop_at(op_idx);

  assign a_val = rd(uop.src_a, ms0, ms1, pe0, pe1, pp0, pp1, fb0, fb1, ff, pr,
                    t1, t2, t3, yr, pos, vel, h_word, model_a10, model_a11,
                    model_b1, error_weight0, error_weight1, rate_feedback,
                    rate_feedforward);
  assign b_val = rd(uop.src_b, ms0, ms1, pe0, pe1, pp0, pp1, fb0, fb1, ff, pr,
                    t1, t2, t3, yr, pos, vel, h_word, model_a10, model_a11,
                    model_b1, error_weight0, error_weight1, rate_feedback,
                    rate_feedforward);

  // First half of an operation: exact product or exact sum/difference.
  assign prod = mrac_pkg::PROD_BITS'(a_val) * mrac_pkg::PROD_BITS'(b_val);

  always_comb begin
    case (uop.op)
      mrac_pkg::OP_MUL: raw_next = prod;
      mrac_pkg::OP_SUB: raw_next = mrac_pkg::PROD_BITS'(a_val) -
                                   mrac_pkg::PROD_BITS'(b_val);
      default:          raw_next = mrac_pkg::PROD_BITS'(a_val) +
                                   mrac_pkg::PROD_BITS'(b_val);
    endcase
  end

  assign sum = raw;

  // Second half: drop fraction bits toward zero for products, then clamp.
  always_comb begin
    shifted = raw >>> mrac_pkg::FRAC_BITS;
    corr    = '0;
    corr[0] = raw[mrac_pkg::PROD_BITS-1] && (raw[mrac_pkg::FRAC_BITS-1:0] != '0);
    if (uop.op == mrac_pkg::OP_MUL) begin
      q_wide = shifted + corr;
    end else begin
      q_wide = sum;
    end
    if (q_wide > mrac_pkg::SAT_HI) begin
      q     = mrac_pkg::SAT_HI[mrac_pkg::WORD_BITS-1:0];
      q_sat = 1'b1;
    end else if (q_wide < mrac_pkg::SAT_LO) begin
      q     = mrac_pkg::SAT_LO[mrac_pkg::WORD_BITS-1:0];
      q_sat = 1'b1;
    end else begin
      q     = q_wide[mrac_pkg::WORD_BITS-1:0];
      q_sat = 1'b0;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      op_idx           <= '0;
      out_valid        <= 1'b0;
      ovf              <= 1'b0;
      step_size        <= mrac_pkg::RST_STEP_SIZE;
      model_a10        <= mrac_pkg::RST_MODEL_A10;
      model_a11        <= mrac_pkg::RST_MODEL_A11;
      model_b1         <= mrac_pkg::RST_MODEL_B1;
      error_weight0    <= mrac_pkg::RST_ERROR_WEIGHT0;
      error_weight1    <= mrac_pkg::RST_ERROR_WEIGHT1;
      rate_feedback    <= mrac_pkg::RST_RATE_FEEDBACK;
      rate_feedforward <= mrac_pkg::RST_RATE_FEEDFORWARD;
      ms0 <= '0;
      ms1 <= '0;
      pe0 <= '0;
      pe1 <= '0;
      pp0 <= '0;
      pp1 <= '0;
      fb0 <= '0;
      fb1 <= '0;
      ff  <= '0;
      pr  <= '0;
    end else begin
      // Register writes; indexes past the list are dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mrac_pkg::CFG_STEP_SIZE:
            step_size <= cfg_data[mrac_pkg::STEP_BITS-1:0];
          mrac_pkg::CFG_MODEL_A10:        model_a10        <= $signed(cfg_data);
          mrac_pkg::CFG_MODEL_A11:        model_a11        <= $signed(cfg_data);
          mrac_pkg::CFG_MODEL_B1:         model_b1         <= $signed(cfg_data);
          mrac_pkg::CFG_ERROR_WEIGHT0:    error_weight0    <= $signed(cfg_data);
          mrac_pkg::CFG_ERROR_WEIGHT1:    error_weight1    <= $signed(cfg_data);
          mrac_pkg::CFG_RATE_FEEDBACK:    rate_feedback    <= $signed(cfg_data);
          mrac_pkg::CFG_RATE_FEEDFORWARD: rate_feedforward <= $signed(cfg_data);
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          // Latch the request and start the schedule.
          if (in_valid) begin
            yr     <= ref_sample;
            pos    <= plant_pos;
            vel    <= plant_vel;
            ovf    <= 1'b0;
            op_idx <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          raw   <= raw_next;
          state <= S_WB;
        end
        S_WB: begin
          ovf <= ovf | q_sat;
          case (uop.dst)
            mrac_pkg::R_MS0: ms0 <= q;
            mrac_pkg::R_MS1: ms1 <= q;
            mrac_pkg::R_PE0: pe0 <= q;
            mrac_pkg::R_PE1: pe1 <= q;
            mrac_pkg::R_FB0: fb0 <= q;
            mrac_pkg::R_FB1: fb1 <= q;
            mrac_pkg::R_FF:  ff  <= q;
            mrac_pkg::R_T1:  t1  <= q;
            mrac_pkg::R_T2:  t2  <= q;
            mrac_pkg::R_T3:  t3  <= q;
            default: ;
          endcase
          if (op_idx == mrac_pkg::LAST_OP) begin
            // Last operation yields u; retire this tick's inputs as history.
            drive     <= q;
            overflow  <= ovf | q_sat;
            out_valid <= 1'b1;
            pp0       <= pos;
            pp1       <= vel;
            pr        <= yr;
            state     <= S_DONE;
          end else begin
            op_idx <= op_idx + 1'b1;
            state  <= S_EXEC;
          end
        end
        S_DONE: begin
          // Hold the result until the consumer takes it.
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/mrac_checker.sv
// Port-level checker for the MRAC step core, bound to the top level.
`timescale 1ns / 1ps

module mrac_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [mrac_pkg::WORD_BITS-1:0] drive,
  input logic                                  overflow
);

  // Never take a new request while a result is still shown.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready high while out_valid is pending");

  // A taken request yields neither a result nor ready in the next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid && !in_ready))
    else $error("result or ready right after request accept");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(drive) && $stable(overflow)))
    else $error("result changed while stalled");

  // After the result is taken, the core is ready again.
  a_ready_after_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("core not ready after result taken");

  // Reset leaves the core idle.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("core not idle after reset");

endmodule

bind mrac_second_order_step_core mrac_checker u_mrac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive     (drive),
  .overflow  (overflow)
);
